// ----- rtl/core/bse_pkg.sv -----
// battery soc estimator: shared widths, voltage-to-charge rom, sequencer states
// no dependencies
package bse_pkg;

  localparam int TABLE_ENTRIES = 21;
  localparam int IDX_W         = 5;
  localparam int ADC_W         = 12;
  localparam int GAIN_W        = 20;
  localparam int ALPHA_W       = 17;
  localparam int SOC_W         = 23;
  localparam int VOLT_W        = 32;
  localparam int MV_W          = 13;
  localparam int PCT_W         = 7;
  localparam int FRAC_W        = 16;
  localparam int MUL_A_W       = 30;
  localparam int MUL_B_W       = 24;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int ACC_W         = SOC_W + FRAC_W + 2;
  localparam int DIV_W         = 32;
  localparam int DIV_CNT_W     = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 20;
  localparam int S_TDATA_W     = 16;
  localparam int M_TDATA_W     = 48;

  localparam logic [ALPHA_W-1:0]   ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(66);
  localparam logic [GAIN_W-1:0]    GAIN_RESET  = GAIN_W'(175277);
  localparam logic [IDX_W-1:0]     IDX_LAST    = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0]     IDX_SEG_END = IDX_W'(TABLE_ENTRIES - 2);

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOLT,
    ST_CLASS,
    ST_SEARCH,
    ST_SPAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FILT,
    ST_FILT_ACC,
    ST_DONE
  } state_t;

  function automatic logic [MV_W-1:0] rom_mv(input idx_t i);
    logic [MV_W-1:0] v;
    case (i)
      5'd0:    v = 13'd4200;
      5'd1:    v = 13'd4150;
      5'd2:    v = 13'd4110;
      5'd3:    v = 13'd4080;
      5'd4:    v = 13'd4020;
      5'd5:    v = 13'd3980;
      5'd6:    v = 13'd3950;
      5'd7:    v = 13'd3910;
      5'd8:    v = 13'd3870;
      5'd9:    v = 13'd3850;
      5'd10:   v = 13'd3840;
      5'd11:   v = 13'd3820;
      5'd12:   v = 13'd3800;
      5'd13:   v = 13'd3790;
      5'd14:   v = 13'd3770;
      5'd15:   v = 13'd3750;
      5'd16:   v = 13'd3730;
      5'd17:   v = 13'd3710;
      5'd18:   v = 13'd3690;
      5'd19:   v = 13'd3610;
      default: v = 13'd3270;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] rom_pct(input idx_t i);
    logic [PCT_W-1:0] p;
    case (i)
      5'd0:    p = 7'd100;
      5'd1:    p = 7'd95;
      5'd2:    p = 7'd90;
      5'd3:    p = 7'd85;
      5'd4:    p = 7'd80;
      5'd5:    p = 7'd75;
      5'd6:    p = 7'd70;
      5'd7:    p = 7'd65;
      5'd8:    p = 7'd60;
      5'd9:    p = 7'd55;
      5'd10:   p = 7'd50;
      5'd11:   p = 7'd45;
      5'd12:   p = 7'd40;
      5'd13:   p = 7'd35;
      5'd14:   p = 7'd30;
      5'd15:   p = 7'd25;
      5'd16:   p = 7'd20;
      5'd17:   p = 7'd15;
      5'd18:   p = 7'd10;
      5'd19:   p = 7'd5;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/bse_mul.sv -----
// battery soc estimator: shared signed multiplier with registered product
// depends on bse_pkg
module bse_mul (
  input  logic                            clk,
  input  logic signed [bse_pkg::MUL_A_W-1:0] a,
  input  logic signed [bse_pkg::MUL_B_W-1:0] b,
  output logic signed [bse_pkg::PROD_W-1:0]  prod
);
  import bse_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- rtl/core/bse_div.sv -----
// battery soc estimator: restoring divider, one quotient bit per cycle
// depends on bse_pkg
module bse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bse_pkg::DIV_W-1:0]   dividend,
  input  logic [bse_pkg::MV_W-1:0]    divisor,
  output logic                        done,
  output logic [bse_pkg::DIV_W-1:0]   quotient
);
  import bse_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MV_W-1:0]      dvs;
  logic [MV_W-1:0]      rem;
  logic [MV_W:0]        rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? MV_W'(rem_sh - {1'b0, dvs}) : rem_sh[MV_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/battery_soc_estimator_unit.sv -----
// battery soc estimator top: sequencer, segment search and filter state
// depends on bse_pkg, bse_mul, bse_div
//
// channel | dir | signals                        | payload
// s       | in  | s_tvalid s_tready s_tdata[15:0] | adc_count[11:0]
// m       | out | m_tvalid m_tready m_tdata[47:0] | raw_soc_q16[22:0] smoothed_soc_q16[45:23]
// cfg     | in  | cfg_valid cfg_ready            | cfg_index[1:0] cfg_data[19:0]
//
// each sample runs the gain multiply and the class check; a voltage outside the table
// goes straight to the filter, otherwise the steps are a segment search of one table
// entry per cycle, the span multiply, the divider with its done cycle,
// and the filter multiply
// s_tready is high only while the sequencer is idle; a result waits in the output
// register and a new sample may be taken meanwhile; the sequencer holds in its last
// state while an earlier result is still unread
// synchronous reset restores register defaults and arms the filter preload
module battery_soc_estimator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bse_pkg::S_TDATA_W-1:0]  s_tdata,   // adc_count
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bse_pkg::M_TDATA_W-1:0]  m_tdata,   // raw_soc_q16, smoothed_soc_q16
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bse_pkg::*;

  state_t state, state_next;

  logic [ALPHA_W-1:0]  alpha;
  logic [GAIN_W-1:0]   gain;
  logic [ADC_W-1:0]    count;
  logic [VOLT_W-1:0]   volt;
  idx_t                idx;
  idx_t                idx_nxt;
  logic [SOC_W-1:0]    raw;
  logic [SOC_W-1:0]    filtered;
  logic                first_pending;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          quo;

  logic [MV_W-1:0]     mv_hi, mv_lo;
  logic [VOLT_W-1:0]   hi_q16, lo_q16, top_q16, bot_q16;
  logic                seg_hit;
  logic [ALPHA_W-1:0]  alpha_sat;
  logic signed [ACC_W-1:0] acc;
  logic                out_free;

  assign idx_nxt  = idx + 1'b1;
  assign mv_hi    = rom_mv(idx);
  assign mv_lo    = rom_mv(idx_nxt);
  assign hi_q16   = VOLT_W'({mv_hi, {FRAC_W{1'b0}}});
  assign lo_q16   = VOLT_W'({mv_lo, {FRAC_W{1'b0}}});
  assign top_q16  = VOLT_W'({rom_mv('0), {FRAC_W{1'b0}}});
  assign bot_q16  = VOLT_W'({rom_mv(IDX_LAST), {FRAC_W{1'b0}}});
  assign seg_hit  = (mv_hi > mv_lo) && (volt <= hi_q16) && (volt >= lo_q16);
  assign alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign acc = $signed({2'b00, filtered, {FRAC_W{1'b0}}}) + $signed(prod[ACC_W-1:0])
             + $signed(ACC_W'(32768));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  bse_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIV_W-1:0]),
    .divisor  (mv_hi - mv_lo),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_VOLT;
      end
      ST_VOLT: begin
        mul_a      = MUL_A_W'(gain);
        mul_b      = MUL_B_W'(count);
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (prod[VOLT_W-1:0] >= top_q16 || prod[VOLT_W-1:0] <= bot_q16) begin
          state_next = ST_FILT;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          state_next = ST_SPAN;
        end else if (idx == IDX_SEG_END) begin
          state_next = ST_FILT;
        end
      end
      ST_SPAN: begin
        mul_a      = MUL_A_W'(volt - lo_q16);
        mul_b      = MUL_B_W'(rom_pct(idx) - rom_pct(idx_nxt));
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_FILT;
      end
      ST_FILT: begin
        mul_a = MUL_A_W'(alpha_sat);
        mul_b = MUL_B_W'({1'b0, raw}) - MUL_B_W'({1'b0, filtered});
        state_next = first_pending ? ST_DONE : ST_FILT_ACC;
      end
      ST_FILT_ACC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= ALPHA_RESET;
      gain          <= GAIN_RESET;
      filtered      <= '0;
      first_pending <= 1'b1;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ALPHA: alpha <= cfg_data[ALPHA_W-1:0];
          CFG_GAIN:  gain  <= cfg_data[GAIN_W-1:0];
          default:   ;
        endcase
      end
      if (state == ST_FILT && first_pending) begin
        filtered      <= raw;
        first_pending <= 1'b0;
      end
      if (state == ST_FILT_ACC) begin
        filtered <= acc[SOC_W+FRAC_W-1:FRAC_W];
      end
      if (state == ST_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) count <= s_tdata[ADC_W-1:0];
      end
      ST_CLASS: begin
        volt <= prod[VOLT_W-1:0];
        idx  <= '0;
        if (prod[VOLT_W-1:0] >= top_q16) begin
          raw <= SOC_W'({rom_pct('0), {FRAC_W{1'b0}}});
        end else begin
          raw <= SOC_W'({rom_pct(IDX_LAST), {FRAC_W{1'b0}}});
        end
      end
      ST_SEARCH: begin
        if (!seg_hit) begin
          idx <= idx_nxt;
          raw <= '0;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) raw <= SOC_W'({rom_pct(idx_nxt), {FRAC_W{1'b0}}}) + quo[SOC_W-1:0];
      end
      ST_DONE: begin
        if (out_free) m_tdata <= M_TDATA_W'({filtered, raw});
      end
      default: ;
    endcase
  end

endmodule

// ----- bench/battery_soc_estimator_unit_test.sv -----
// self-checking bench for battery_soc_estimator_unit: a directed stimulus table, then random
// phases under several register settings and idle patterns, each result checked against a model
// depends on bse_pkg and battery_soc_estimator_unit
module battery_soc_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOC_W = bse_pkg::SOC_W;
  localparam int ADC_W = bse_pkg::ADC_W;
  localparam int CFG_IDX_W = bse_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bse_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [SOC_W-1:0] SOC_FULL = SOC_W'(6553600);

  typedef struct packed {
    logic [SOC_W-1:0] raw;
    logic [SOC_W-1:0] smooth;
  } soc_pair_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [ADC_W-1:0]       adc;
    bit                     typed;
    logic [SOC_W-1:0]       raw;
    logic [SOC_W-1:0]       smooth;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [bse_pkg::S_TDATA_W-1:0]     s_tdata = '0;   // adc_count
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [bse_pkg::M_TDATA_W-1:0]     m_tdata;        // raw_soc_q16, smoothed_soc_q16
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index = '0;
  logic [CFG_DATA_W-1:0]             cfg_data = '0;

  logic [16:0]      alpha_shadow;
  logic [19:0]      gain_shadow;
  logic [SOC_W-1:0] filt_shadow;
  bit               preload_armed;

  soc_pair_t soc_expect_q[$];
  soc_pair_t oldest_soc;
  stim_row_t dir_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  battery_soc_estimator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned knot_mv(input int k);
    int unsigned v;
    case (k)
      0: v = 4200;   1: v = 4150;   2: v = 4110;   3: v = 4080;   4: v = 4020;
      5: v = 3980;   6: v = 3950;   7: v = 3910;   8: v = 3870;   9: v = 3850;
      10: v = 3840;  11: v = 3820;  12: v = 3800;  13: v = 3790;  14: v = 3770;
      15: v = 3750;  16: v = 3730;  17: v = 3710;  18: v = 3690;  19: v = 3610;
      default: v = 3270;
    endcase
    return v;
  endfunction

  function automatic int unsigned knot_pct(input int k);
    return (k <= 20) ? 100 - 5 * k : 0;
  endfunction

  function automatic logic [SOC_W-1:0] interp_soc(input logic [63:0] volt);
    int n;
    int k;
    logic [63:0] hi, lo, span, width, frac;
    n = bse_pkg::TABLE_ENTRIES;
    if (n < 2) n = 2;
    if (n > 32) n = 32;
    if (volt >= (64'(knot_mv(0)) << 16)) return SOC_W'(64'(knot_pct(0)) << 16);
    if (volt <= (64'(knot_mv(n - 1)) << 16)) return SOC_W'(64'(knot_pct(n - 1)) << 16);
    for (k = 0; k + 1 < n; k++) begin
      if (knot_mv(k) <= knot_mv(k + 1)) continue;
      hi = 64'(knot_mv(k)) << 16;
      lo = 64'(knot_mv(k + 1)) << 16;
      if (volt <= hi && volt >= lo) begin
        width = 64'(knot_mv(k) - knot_mv(k + 1));
        span = 64'(knot_pct(k) - knot_pct(k + 1));
        frac = ((volt - lo) * span) / width;
        return SOC_W'((64'(knot_pct(k + 1)) << 16) + frac);
      end
    end
    return '0;
  endfunction

  task automatic step_soc_model(input logic [ADC_W-1:0] adc, output soc_pair_t res);
    logic [63:0] volt, a, acc;
    volt = 64'(adc) * 64'(gain_shadow);
    res.raw = interp_soc(volt);
    if (preload_armed) begin
      filt_shadow = res.raw;
      preload_armed = 1'b0;
    end else begin
      a = (alpha_shadow > 17'd65536) ? 64'd65536 : 64'(alpha_shadow);
      acc = a * 64'(res.raw) + (64'd65536 - a) * 64'(filt_shadow) + 64'd32768;
      filt_shadow = acc[16 +: SOC_W];
    end
    res.smooth = filt_shadow;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic send_sample(input stim_row_t row);
    soc_pair_t res;
    cfg_valid <= 1'b0;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= bse_pkg::S_TDATA_W'(row.adc);
    do @(posedge clk); while (!s_tready);
    step_soc_model(row.adc, res);
    if (row.typed) begin
      res.raw = row.raw;
      res.smooth = row.smooth;
    end
    soc_expect_q.push_back(res);
    samples_sent++;
  endtask

  // valid stays high across back-to-back writes; the next sample lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bse_pkg::CFG_ALPHA: alpha_shadow = data[16:0];
      bse_pkg::CFG_GAIN:  gain_shadow = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (soc_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_sample(input logic [ADC_W-1:0] adc);
    dir_rows.push_back('{ROW_SAMPLE, '0, '0, adc, 1'b0, '0, '0});
  endtask

  task automatic add_checked(input logic [ADC_W-1:0] adc, input logic [SOC_W-1:0] raw,
                             input logic [SOC_W-1:0] smooth);
    dir_rows.push_back('{ROW_SAMPLE, '0, '0, adc, 1'b1, raw, smooth});
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    dir_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0, '0});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (soc_expect_q.size() == 0) begin
          report_mismatch($sformatf("result with no sample pending, m_tdata=%h", m_tdata));
        end else begin
          oldest_soc = soc_expect_q.pop_front();
          if (m_tdata[SOC_W-1:0] !== oldest_soc.raw)
            report_mismatch($sformatf("raw_soc_q16 got %0d expected %0d",
                                      m_tdata[SOC_W-1:0], oldest_soc.raw));
          if (m_tdata[2*SOC_W-1:SOC_W] !== oldest_soc.smooth)
            report_mismatch($sformatf("smoothed_soc_q16 got %0d expected %0d",
                                      m_tdata[2*SOC_W-1:SOC_W], oldest_soc.smooth));
        end
      end
      m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL battery_soc_estimator_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int p;
    int n;
    int sel;
    longint target;
    longint pick;
    stim_row_t row;

    alpha_shadow = bse_pkg::ALPHA_RESET;
    gain_shadow = bse_pkg::GAIN_RESET;
    filt_shadow = '0;
    preload_armed = 1'b1;

    // first sample after reset loads the filter directly
    add_checked(12'd4095, SOC_FULL, SOC_FULL);
    add_sample(12'd0);
    add_sample(12'hAAA);
    add_sample(12'h555);
    add_sample(12'd1222);
    add_sample(12'd1570);
    add_write(bse_pkg::CFG_ALPHA, 20'd0);
    add_sample(12'd1400);
    // alpha above one acts as one, and the upper data bits are dropped
    add_write(bse_pkg::CFG_ALPHA, 20'hFFFFF);
    add_sample(12'd1300);
    // 2 mV per count lands exactly on table entries
    add_write(bse_pkg::CFG_GAIN, 20'd131072);
    add_checked(12'd2100, SOC_FULL, SOC_FULL);
    add_checked(12'd1635, '0, '0);
    add_sample(12'd1905);
    add_checked(12'd1900, SOC_W'(40 << 16), SOC_W'(40 << 16));
    add_checked(12'd1805, SOC_W'(5 << 16), SOC_W'(5 << 16));
    add_checked(12'd1634, '0, '0);
    add_write(bse_pkg::CFG_GAIN, 20'd0);
    add_checked(12'd4095, '0, '0);
    add_write(bse_pkg::CFG_GAIN, 20'hFFFFF);
    add_checked(12'd4095, SOC_FULL, SOC_FULL);
    // unknown indexes must leave both registers alone
    add_write(CFG_SPARE_2, 20'd0);
    add_write(CFG_SPARE_3, 20'hFFFFF);
    add_checked(12'd1, '0, '0);
    add_write(bse_pkg::CFG_ALPHA, 20'(bse_pkg::ALPHA_RESET));
    add_write(bse_pkg::CFG_GAIN, bse_pkg::GAIN_RESET);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_results();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_sample(dir_rows[r]);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      case (p)
        0: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'(bse_pkg::ALPHA_RESET));
          write_reg(bse_pkg::CFG_GAIN, bse_pkg::GAIN_RESET);
        end
        1: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'd0);
          write_reg(bse_pkg::CFG_GAIN, 20'd131072);
        end
        2: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'd65536);
          write_reg(bse_pkg::CFG_GAIN, 20'($urandom_range(400000, 100000)));
        end
        3: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'hFFFFF);
          write_reg(bse_pkg::CFG_GAIN, 20'hFFFFF);
        end
        4: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'($urandom()));
          write_reg(bse_pkg::CFG_GAIN, 20'($urandom()));
        end
        5: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'($urandom_range(65536)));
          write_reg(bse_pkg::CFG_GAIN, 20'($urandom_range(260000, 120000)));
        end
        6: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'd32768);
          write_reg(bse_pkg::CFG_GAIN, 20'd65536);
        end
        default: begin
          write_reg(bse_pkg::CFG_ALPHA, 20'($urandom_range(4096, 1)));
          write_reg(bse_pkg::CFG_GAIN, bse_pkg::GAIN_RESET);
          write_reg(CFG_SPARE_2, 20'($urandom()));
          write_reg(CFG_SPARE_3, 20'($urandom()));
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(99);
        if (gain_shadow == 0 || sel < 20) begin
          pick = $urandom_range(4095);
        end else begin
          // aim at the table range or right at one of its entries
          if (sel < 35)
            target = longint'(knot_mv($urandom_range(20))) << 16;
          else
            target = longint'($urandom_range(4250 * 65536, 3200 * 65536));
          pick = target / longint'(gain_shadow);
          if (sel < 35) pick = pick + longint'($urandom_range(2)) - 1;
          if (pick < 0) pick = 0;
          if (pick > 4095) pick = 4095;
        end
        row = '{ROW_SAMPLE, '0, '0, ADC_W'(pick), 1'b0, '0, '0};
        send_sample(row);
      end
    end

    drain_results();
    cfg_valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (soc_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", soc_expect_q.size()));

    $display("covered %0d samples and %0d results over %0d register writes,",
             samples_sent, results_seen, cfg_writes);
    $display("gain and alpha extremes, table entry boundaries and four stall patterns");
    if (err_count == 0) begin
      $display("PASS battery_soc_estimator_unit");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL battery_soc_estimator_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bse_pkg.sv
rtl/core/bse_mul.sv
rtl/core/bse_div.sv
rtl/core/battery_soc_estimator_unit.sv
bench/battery_soc_estimator_unit_test.sv
